// ===== hdl/dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types, constants and operation codes of the duplicate frame
// rejection table.
// ----------------------------------------------------------------------------
package dfr_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = 16;
  localparam int CTR_W    = 8;
  localparam int EXPIRY_W = 8;

  localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 8'd3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CHECK = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   addr;
    logic [CTR_W-1:0]    ctr;
    logic [EXPIRY_W-1:0] expiry;
  } entry_t;

  // running outcome of one walk around the ring
  typedef struct packed {
    logic hit;
    logic placed;
  } walk_flags_t;

endpackage

// ===== hdl/dfr_if.sv =====
// ----------------------------------------------------------------------------
// dfr_in_if / dfr_out_if
// Valid/ready channels carrying table operations and their results.
// ----------------------------------------------------------------------------
interface dfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] short_addr;
  logic [7:0]  frame_counter;

  modport source (output valid, func, short_addr, frame_counter, input ready);
  modport sink   (input valid, func, short_addr, frame_counter, output ready);
endinterface

interface dfr_out_if;
  logic valid;
  logic ready;
  logic is_duplicate;
  logic table_full;

  modport source (output valid, is_duplicate, table_full, input ready);
  modport sink   (input valid, is_duplicate, table_full, output ready);
endinterface

// ===== hdl/dfr_cell.sv =====
// ----------------------------------------------------------------------------
// dfr_cell
// One table slot; passes its entry to the next cell on every shift.
// ----------------------------------------------------------------------------
module dfr_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift,
  input  dfr_pkg::entry_t entry_in,
  output dfr_pkg::entry_t entry
);
  import dfr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (shift) begin
      entry.valid <= entry_in.valid;
    end
    if (shift) begin
      entry.addr   <= entry_in.addr;
      entry.ctr    <= entry_in.ctr;
      entry.expiry <= entry_in.expiry;
    end
  end

endmodule

// ===== hdl/dfr_head.sv =====
// ----------------------------------------------------------------------------
// dfr_head
// Operation logic at the ring's loop-back point: applies check, add or tick
// to the entry passing from the last cell to the first.
// ----------------------------------------------------------------------------
module dfr_head (
  input  dfr_pkg::func_t              func,
  input  logic [dfr_pkg::ADDR_W-1:0]  short_addr,
  input  logic [dfr_pkg::CTR_W-1:0]   frame_counter,
  input  logic [dfr_pkg::EXPIRY_W-1:0] expiry_ticks,
  input  dfr_pkg::walk_flags_t        flags,
  input  dfr_pkg::entry_t             entry_in,
  output dfr_pkg::walk_flags_t        flags_next,
  output dfr_pkg::entry_t             entry_out
);
  import dfr_pkg::*;

  logic match;

  assign match = entry_in.valid && (entry_in.addr == short_addr) &&
                 (entry_in.ctr == frame_counter);

  always_comb begin
    entry_out  = entry_in;
    flags_next = flags;
    case (func)
      FUNC_CHECK: begin
        flags_next.hit = flags.hit | match;
      end
      FUNC_ADD: begin
        if (!flags.placed && !entry_in.valid) begin
          entry_out.valid  = 1'b1;
          entry_out.addr   = short_addr;
          entry_out.ctr    = frame_counter;
          entry_out.expiry = expiry_ticks;
          flags_next.placed = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (entry_in.valid) begin
          if (entry_in.expiry == '0) begin
            entry_out.valid = 1'b0;
          end else begin
            entry_out.expiry = entry_in.expiry - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/duplicate_frame_reject_table_unit.sv =====
// ----------------------------------------------------------------------------
// duplicate_frame_reject_table_unit
// An item is taken in S_IDLE and rotates the ring of slot cells once in S_WALK,
// one slot through the head logic per cycle; S_DONE then waits for a free
// output register and registers the result. No new item is taken until then,
// but a new item is taken while the previous result still waits in the output
// register. Reset empties the table and sets expiry_ticks to 3.
// ----------------------------------------------------------------------------
module duplicate_frame_reject_table_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  dfr_in_if.sink     in_ch,
  dfr_out_if.source  out_ch
);
  import dfr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t                state;
  logic [IDX_W-1:0]      cnt;
  func_t                 op_func;
  logic [ADDR_W-1:0]     op_addr;
  logic [CTR_W-1:0]      op_ctr;
  logic [EXPIRY_W-1:0]   expiry_ticks;
  walk_flags_t           flags;
  walk_flags_t           flags_next;
  logic                  shift;
  logic                  last_step;
  logic                  out_free;

  entry_t cell_q [TABLE_ENTRIES];
  entry_t head_out;

  assign shift     = (state == S_WALK);
  assign last_step = (cnt == IDX_W'(TABLE_ENTRIES - 1));
  assign out_free  = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_ticks <= EXPIRY_RESET;
    end else if (cfg_wr_en) begin
      expiry_ticks <= cfg_wr_data;
    end
  end

  dfr_head u_head (
    .func          (op_func),
    .short_addr    (op_addr),
    .frame_counter (op_ctr),
    .expiry_ticks  (expiry_ticks),
    .flags         (flags),
    .entry_in      (cell_q[TABLE_ENTRIES-1]),
    .flags_next    (flags_next),
    .entry_out     (head_out)
  );

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      dfr_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (shift),
        .entry_in (head_out),
        .entry    (cell_q[i])
      );
    end else begin : g_rest
      dfr_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (shift),
        .entry_in (cell_q[i-1]),
        .entry    (cell_q[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && (state != S_DONE)) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_func <= func_t'(in_ch.func);
            op_addr <= in_ch.short_addr;
            op_ctr  <= in_ch.frame_counter;
            flags   <= '0;
            cnt     <= '0;
            state   <= S_WALK;
          end
        end
        S_WALK: begin
          flags <= flags_next;
          cnt   <= cnt + 1'b1;
          if (last_step) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_ch.valid        <= 1'b1;
            out_ch.is_duplicate <= (op_func == FUNC_CHECK) && flags.hit;
            out_ch.table_full   <= (op_func == FUNC_ADD) && !flags.placed;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the duplicate frame rejection table. A shadow copy
// of the table predicts all results but those of typed rows. A short stimulus
// table covers extremes, the full table and a zero expiry setting. Random phases
// follow, each with its own expiry setting, under bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import dfr_pkg::*;

  localparam int PHASE_ITEMS = 115;
  localparam int STALL_LIMIT = 4000;
  localparam int PLAN_ROWS   = 19;

  typedef struct packed {
    logic is_duplicate;
    logic table_full;
  } verdict_t;

  typedef enum logic {ROW_OP, ROW_CFG} row_kind_t;

  // cfg rows carry the register value in ctr
  typedef struct packed {
    row_kind_t         kind;
    func_t             func;
    logic [ADDR_W-1:0] addr;
    logic [CTR_W-1:0]  ctr;
    logic [4:0]        reps;
    logic              typed;
    verdict_t          want;
  } plan_row_t;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_CFG, FUNC_NONE,  16'h0000, 8'h00, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_ADD,   16'h1234, 8'h56, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_TICK,  16'h0000, 8'h00, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_CHECK, 16'h1234, 8'h56, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_CFG, FUNC_NONE,  16'h0000, 8'hFF, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_CHECK, 16'h0000, 8'h00, 5'd1,  1'b1, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_ADD,   16'hFFFF, 8'hFF, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_CFG, FUNC_NONE,  16'h0000, 8'h02, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_ADD,   16'hFFFF, 8'hFF, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_ADD,   16'h0000, 8'h00, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_CHECK, 16'hFFFF, 8'hFF, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_CHECK, 16'hFFFF, 8'hFE, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_CHECK, 16'h7FFF, 8'hFF, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_CHECK, 16'h0000, 8'h00, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_NONE,  16'hFFFF, 8'hFF, 5'd1,  1'b1, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_ADD,   16'h8000, 8'h80, 5'd13, 1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_ADD,   16'h5555, 8'hAA, 5'd1,  1'b1, '{1'b0, 1'b1}},
    '{ROW_OP,  FUNC_CHECK, 16'h800C, 8'h80, 5'd1,  1'b0, '{1'b0, 1'b0}},
    '{ROW_OP,  FUNC_TICK,  16'h0000, 8'h00, 5'd1,  1'b0, '{1'b0, 1'b0}}
  };

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [EXPIRY_W-1:0] cfg_wr_data;

  dfr_in_if  in_ch ();
  dfr_out_if out_ch ();

  duplicate_frame_reject_table_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // shadow copy of the table
  logic                shadow_valid  [TABLE_ENTRIES];
  logic [ADDR_W-1:0]   shadow_addr   [TABLE_ENTRIES];
  logic [CTR_W-1:0]    shadow_ctr    [TABLE_ENTRIES];
  logic [EXPIRY_W-1:0] shadow_expiry [TABLE_ENTRIES];
  logic [EXPIRY_W-1:0] shadow_expiry_ticks;

  verdict_t          pending_verdicts [$];
  logic [ADDR_W-1:0] addr_pool [4];

  int burst_left;
  int items_sent;
  int settings_used;
  int mismatches;
  int dup_seen;
  int full_seen;
  int idle_cycles;
  int rx_mode;
  int rx_left;
  int rx_hold;

  always #6 clk = ~clk;

  function automatic verdict_t table_verdict(input func_t f, input logic [ADDR_W-1:0] a,
                                             input logic [CTR_W-1:0] c);
    verdict_t v;
    v = '0;
    case (f)
      FUNC_CHECK: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (shadow_valid[i] && shadow_addr[i] == a && shadow_ctr[i] == c)
            v.is_duplicate = 1'b1;
      end
      FUNC_ADD: begin
        v.table_full = 1'b1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (v.table_full && !shadow_valid[i]) begin
            shadow_valid[i]  = 1'b1;
            shadow_addr[i]   = a;
            shadow_ctr[i]    = c;
            shadow_expiry[i] = shadow_expiry_ticks;
            v.table_full     = 1'b0;
          end
        end
      end
      FUNC_TICK: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (shadow_valid[i]) begin
            if (shadow_expiry[i] == '0) shadow_valid[i] = 1'b0;
            else shadow_expiry[i] = shadow_expiry[i] - 1'b1;
          end
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  // called at a rising edge; returns at the edge of the transfer or after the gap
  task automatic send_op(input func_t f, input logic [ADDR_W-1:0] a,
                         input logic [CTR_W-1:0] c, input logic use_given,
                         input verdict_t given, output verdict_t got);
    in_ch.valid         <= 1'b1;
    in_ch.func          <= f;
    in_ch.short_addr    <= a;
    in_ch.frame_counter <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = table_verdict(f, a, c);
    pending_verdicts.push_back(use_given ? given : got);
    items_sent++;
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
    end
  endtask

  task automatic write_expiry(input logic [EXPIRY_W-1:0] val);
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_expiry_ticks = val;
    settings_used++;
  endtask

  task automatic pick_frame(output logic [ADDR_W-1:0] a, output logic [CTR_W-1:0] c);
    if ($urandom_range(0, 9) < 7) begin
      a = addr_pool[$urandom_range(0, 3)];
      c = CTR_W'($urandom_range(0, 3));
    end else begin
      a = ADDR_W'($urandom);
      c = CTR_W'($urandom);
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_mode = 0;
      rx_left = 50;
      rx_hold = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(40, 200);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= (rx_left % 8 == 0);
        default: begin
          if (rx_hold != 0) begin
            out_ch.ready <= 1'b0;
            rx_hold--;
          end else begin
            out_ch.ready <= 1'b1;
            rx_hold = ($urandom_range(0, 1) != 0) ? $urandom_range(5, 40) : 0;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (out_ch.is_duplicate === 1'b1) dup_seen++;
      if (out_ch.table_full === 1'b1) full_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at %0t: is_duplicate %b table_full %b",
                   $realtime, out_ch.is_duplicate, out_ch.table_full);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_ch.is_duplicate !== want.is_duplicate ||
            out_ch.table_full !== want.table_full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: is_duplicate exp %b got %b, table_full exp %b got %b",
                     $realtime, want.is_duplicate, out_ch.is_duplicate,
                     want.table_full, out_ch.table_full);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    verdict_t            v;
    logic [ADDR_W-1:0]   a;
    logic [CTR_W-1:0]    c;
    logic [EXPIRY_W-1:0] expiry_plan [7];
    int                  n;
    int                  pick;

    clk                 = 1'b0;
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    in_ch.valid         = 1'b0;
    in_ch.func          = FUNC_CHECK;
    in_ch.short_addr    = '0;
    in_ch.frame_counter = '0;
    out_ch.ready        = 1'b0;
    burst_left          = 1;
    items_sent          = 0;
    settings_used       = 0;
    mismatches          = 0;
    dup_seen            = 0;
    full_seen           = 0;
    idle_cycles         = 0;
    shadow_expiry_ticks = EXPIRY_RESET;
    foreach (shadow_valid[i]) begin
      shadow_valid[i]  = 1'b0;
      shadow_addr[i]   = '0;
      shadow_ctr[i]    = '0;
      shadow_expiry[i] = '0;
    end
    foreach (addr_pool[i]) addr_pool[i] = ADDR_W'($urandom);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        write_expiry(plan[r].ctr);
      end else begin
        for (int k = 0; k < plan[r].reps; k++)
          send_op(plan[r].func, ADDR_W'(plan[r].addr + k), plan[r].ctr,
                  plan[r].typed, plan[r].want, v);
      end
    end

    expiry_plan = '{8'd1, 8'd3, 8'd0, 8'd2, EXPIRY_W'($urandom_range(0, 8)), 8'd5, 8'd255};
    foreach (expiry_plan[p]) begin
      write_expiry(expiry_plan[p]);
      n = 0;
      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          // normal receive: look up the frame, then record it if new
          pick_frame(a, c);
          send_op(FUNC_CHECK, a, c, 1'b0, '0, v);
          n++;
          if (!v.is_duplicate) begin
            send_op(FUNC_ADD, a, c, 1'b0, '0, v);
            n++;
          end
        end else if (pick < 75) begin
          send_op(FUNC_TICK, ADDR_W'($urandom), CTR_W'($urandom), 1'b0, '0, v);
          n++;
        end else if (pick < 85) begin
          pick_frame(a, c);
          send_op(FUNC_ADD, a, c, 1'b0, '0, v);
          n++;
        end else if (pick < 95) begin
          pick_frame(a, c);
          send_op(FUNC_CHECK, a, c, 1'b0, '0, v);
          n++;
        end else begin
          send_op(FUNC_NONE, ADDR_W'($urandom), CTR_W'($urandom), 1'b0, '0, v);
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d operations under %0d expiry settings, from 0 to 255",
             items_sent, settings_used);
    $display("the table reported %0d duplicate frames and dropped %0d adds as full",
             dup_seen, full_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failed checks", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
